// ----- design/mau_pkg.sv -----
// Package with the shared types, constants and unit opcodes of the modular arithmetic unit.
package mau_pkg;

    localparam int RESIDUE_BITS  = 31;
    localparam int EXPONENT_BITS = 63;
    localparam int CNT_BITS      = $clog2(RESIDUE_BITS);
    localparam int PADDR_BITS    = 3;

    localparam logic [RESIDUE_BITS-1:0] MODULUS_RESET = RESIDUE_BITS'(64'd1000000007);

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_POW = 3'd4;
    localparam logic [2:0] MODE_INV = 3'd5;
    localparam logic [2:0] MODE_NEG = 3'd6;

    localparam logic [PADDR_BITS-1:0] ADDR_MODULUS = PADDR_BITS'(0);

    typedef enum logic [1:0] {
        OP_DBL = 2'd0,
        OP_ADD = 2'd1,
        OP_NEG = 2'd2
    } unit_op_t;

    typedef struct packed {
        logic [2:0]               mode;
        logic [RESIDUE_BITS-1:0]  operand_a;
        logic [RESIDUE_BITS-1:0]  operand_b;
        logic [EXPONENT_BITS-1:0] exponent;
    } req_t;

    typedef struct packed {
        logic [RESIDUE_BITS-1:0] result;
        logic                    status;
    } rsp_t;

endpackage

// ----- design/mau_unit.sv -----
// Shared modular step unit: doubling add, plain add and negate, each reduced by a given modulus.
module mau_unit #(
    parameter int WIDTH = 31
) (
    input  mau_pkg::unit_op_t op,
    input  logic [WIDTH-1:0]  r,
    input  logic [WIDTH-1:0]  x,
    input  logic [WIDTH-1:0]  m,
    output logic [WIDTH-1:0]  res,
    output logic              ge
);

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    logic             ge2;
    logic [WIDTH+1:0] red;

    assign m1  = {2'b00, m};
    assign m2  = {1'b0, m, 1'b0};
    assign sum = ((op == mau_pkg::OP_DBL) ? {1'b0, r, 1'b0} : {2'b00, r}) + {2'b00, x};
    assign ge  = (sum >= m1);
    assign ge2 = (sum >= m2);
    assign red = ge2 ? (sum - m2) : (ge ? (sum - m1) : sum);

    always_comb
    begin
        case (op)
            mau_pkg::OP_NEG: res = (x == '0) ? '0 : (m - x);
            default:         res = red[WIDTH-1:0];
        endcase
    end

endmodule

// ----- design/mau_cfg.sv -----
// Configuration register file holding the modulus behind an APB-style port.
module mau_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mau_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic [mau_pkg::RESIDUE_BITS-1:0]    modulus
);

    logic [mau_pkg::RESIDUE_BITS-1:0] modulus_reg;
    logic [mau_pkg::RESIDUE_BITS-1:0] modulus_next;
    logic                             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == mau_pkg::ADDR_MODULUS);

    always_comb
    begin
        modulus_next = modulus_reg;
        if (wr_en)
        begin
            modulus_next = pwdata[mau_pkg::RESIDUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mau_pkg::MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == mau_pkg::ADDR_MODULUS)
        begin
            prdata = 32'(modulus_reg);
        end
    end

    assign modulus = modulus_reg;

endmodule

// ----- design/modular_arithmetic_unit.sv -----
// Top level of the modular arithmetic unit: sequencer around one shared modular step unit.
// An item is taken when start is high and busy is low; request carries mode, both operands
// and the exponent. Each item produces exactly one response, shown for a single cycle while
// done is high; the receiver cannot stall it. busy stays high from the accepting edge until
// the cycle in which done rises; an item answered straight from idle never raises busy.
// All work runs on one shared combinational unit: a doubling add, a plain add or a negate,
// reduced by the modulus or, in division, by the divisor. Both operands are first reduced by
// a product with one; a product is built from doubling adds over the multiplier bits. Add and
// negate then finish on the unit directly; subtract negates the second operand, then adds.
// Power takes up to 2*63 products. Inverse and divide run extended Euclid, each step a
// restoring division on the same unit plus one product, a negate and an add. A modulus below
// two or an unused mode answers in the next cycle with zero. The user must write the modulus
// through the APB port only while the block is idle; the block does not enforce it. Reset
// restores it to 1000000007 and leaves the block idle with no pending item.
module modular_arithmetic_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mau_pkg::req_t                  request,
    output logic                           done,
    output mau_pkg::rsp_t                  response,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mau_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int R = mau_pkg::RESIDUE_BITS;
    localparam int E = mau_pkg::EXPONENT_BITS;
    localparam int C = mau_pkg::CNT_BITS;
    localparam logic [C-1:0] CNT_TOP = C'(R - 1);
    localparam logic [R-1:0] ONE = R'(1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL  = 10'b0000000010,
        S_ADD  = 10'b0000000100,
        S_SUBN = 10'b0000001000,
        S_NEG  = 10'b0000010000,
        S_PW   = 10'b0000100000,
        S_EU   = 10'b0001000000,
        S_EDIV = 10'b0010000000,
        S_ENEG = 10'b0100000000,
        S_EADD = 10'b1000000000
    } state_t;

    typedef enum logic [2:0] {
        RET_RA  = 3'd0,
        RET_RB  = 3'd1,
        RET_FIN = 3'd2,
        RET_PA  = 3'd3,
        RET_PB  = 3'd4,
        RET_EQ  = 3'd5
    } ret_t;

    logic [R-1:0] modulus;

    state_t        state_reg, state_next;
    logic          done_reg, done_next;
    ret_t          ret_reg, ret_next;
    logic [C-1:0]  cnt_reg, cnt_next;
    logic [2:0]    mode_reg, mode_next;
    logic [R-1:0]  a_reg, a_next;
    logic [R-1:0]  b_reg, b_next;
    logic [E-1:0]  e_reg, e_next;
    logic [R-1:0]  pr_reg, pr_next;
    logic [R-1:0]  mx_reg, mx_next;
    logic [R-1:0]  my_reg, my_next;
    logic [R-1:0]  acc_reg, acc_next;
    logic [R-1:0]  base_reg, base_next;
    logic [R-1:0]  r0_reg, r0_next;
    logic [R-1:0]  r1_reg, r1_next;
    logic [R-1:0]  c0_reg, c0_next;
    logic [R-1:0]  c1_reg, c1_next;
    logic [R-1:0]  rem_reg, rem_next;
    logic [R-1:0]  q_reg, q_next;
    mau_pkg::rsp_t rsp_reg, rsp_next;

    mau_pkg::unit_op_t u_op;
    logic [R-1:0]      u_r;
    logic [R-1:0]      u_x;
    logic [R-1:0]      u_m;
    logic [R-1:0]      u_res;
    logic              u_ge;
    logic [R-1:0]      q_shift;

    mau_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .modulus (modulus)
    );

    mau_unit #(
        .WIDTH (R)
    ) u_unit (
        .op  (u_op),
        .r   (u_r),
        .x   (u_x),
        .m   (u_m),
        .res (u_res),
        .ge  (u_ge)
    );

    assign q_shift = {q_reg[R-2:0], u_ge};

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        e_next     = e_reg;
        pr_next    = pr_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        rsp_next   = rsp_reg;
        u_op       = mau_pkg::OP_DBL;
        u_r        = pr_reg;
        u_x        = '0;
        u_m        = modulus;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = request.mode;
                    a_next    = request.operand_a;
                    b_next    = request.operand_b;
                    e_next    = request.exponent;
                    if ((modulus < R'(2)) || (request.mode > mau_pkg::MODE_NEG))
                    begin
                        rsp_next   = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        mx_next    = ONE;
                        my_next    = request.operand_a;
                        pr_next    = '0;
                        cnt_next   = CNT_TOP;
                        ret_next   = RET_RA;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                u_op    = mau_pkg::OP_DBL;
                u_r     = pr_reg;
                u_x     = my_reg[cnt_reg] ? mx_reg : '0;
                pr_next = u_res;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - C'(1);
                end
                else
                begin
                    case (ret_reg)
                        RET_RA:
                        begin
                            a_next   = u_res;
                            mx_next  = ONE;
                            my_next  = b_reg;
                            pr_next  = '0;
                            cnt_next = CNT_TOP;
                            ret_next = RET_RB;
                        end
                        RET_RB:
                        begin
                            b_next = u_res;
                            case (mode_reg)
                                mau_pkg::MODE_ADD: state_next = S_ADD;
                                mau_pkg::MODE_SUB: state_next = S_SUBN;
                                mau_pkg::MODE_NEG: state_next = S_NEG;
                                mau_pkg::MODE_MUL:
                                begin
                                    mx_next  = a_reg;
                                    my_next  = u_res;
                                    pr_next  = '0;
                                    cnt_next = CNT_TOP;
                                    ret_next = RET_FIN;
                                end
                                mau_pkg::MODE_POW:
                                begin
                                    acc_next   = ONE;
                                    base_next  = a_reg;
                                    state_next = S_PW;
                                end
                                mau_pkg::MODE_DIV:
                                begin
                                    r0_next    = u_res;
                                    r1_next    = modulus;
                                    c0_next    = ONE;
                                    c1_next    = '0;
                                    state_next = S_EU;
                                end
                                mau_pkg::MODE_INV:
                                begin
                                    r0_next    = a_reg;
                                    r1_next    = modulus;
                                    c0_next    = ONE;
                                    c1_next    = '0;
                                    state_next = S_EU;
                                end
                                default:
                                begin
                                    rsp_next   = '0;
                                    done_next  = 1'b1;
                                    state_next = S_IDLE;
                                end
                            endcase
                        end
                        RET_PA:
                        begin
                            acc_next = u_res;
                            mx_next  = base_reg;
                            my_next  = base_reg;
                            pr_next  = '0;
                            cnt_next = CNT_TOP;
                            ret_next = RET_PB;
                        end
                        RET_PB:
                        begin
                            base_next  = u_res;
                            e_next     = e_reg >> 1;
                            state_next = S_PW;
                        end
                        RET_EQ:
                        begin
                            state_next = S_ENEG;
                        end
                        default:
                        begin
                            rsp_next.result = u_res;
                            rsp_next.status = 1'b0;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                u_op            = mau_pkg::OP_ADD;
                u_r             = a_reg;
                u_x             = b_reg;
                rsp_next.result = u_res;
                rsp_next.status = 1'b0;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_SUBN:
            begin
                u_op       = mau_pkg::OP_NEG;
                u_x        = b_reg;
                b_next     = u_res;
                state_next = S_ADD;
            end
            S_NEG:
            begin
                u_op            = mau_pkg::OP_NEG;
                u_x             = a_reg;
                rsp_next.result = u_res;
                rsp_next.status = 1'b0;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_PW:
            begin
                if (e_reg == '0)
                begin
                    rsp_next.result = acc_reg;
                    rsp_next.status = 1'b0;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    mx_next    = base_reg;
                    my_next    = e_reg[0] ? acc_reg : base_reg;
                    ret_next   = e_reg[0] ? RET_PA : RET_PB;
                    pr_next    = '0;
                    cnt_next   = CNT_TOP;
                    state_next = S_MUL;
                end
            end
            S_EU:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg != ONE)
                    begin
                        rsp_next.result = '0;
                        rsp_next.status = 1'b1;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (mode_reg == mau_pkg::MODE_INV)
                    begin
                        rsp_next.result = c0_reg;
                        rsp_next.status = 1'b0;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        mx_next    = a_reg;
                        my_next    = c0_reg;
                        pr_next    = '0;
                        cnt_next   = CNT_TOP;
                        ret_next   = RET_FIN;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = CNT_TOP;
                    state_next = S_EDIV;
                end
            end
            S_EDIV:
            begin
                u_op     = mau_pkg::OP_DBL;
                u_r      = rem_reg;
                u_x      = R'(r0_reg[cnt_reg]);
                u_m      = r1_reg;
                rem_next = u_res;
                q_next   = q_shift;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - C'(1);
                end
                else
                begin
                    mx_next    = c1_reg;
                    my_next    = q_shift;
                    pr_next    = '0;
                    cnt_next   = CNT_TOP;
                    ret_next   = RET_EQ;
                    state_next = S_MUL;
                end
            end
            S_ENEG:
            begin
                u_op       = mau_pkg::OP_NEG;
                u_x        = pr_reg;
                pr_next    = u_res;
                state_next = S_EADD;
            end
            S_EADD:
            begin
                u_op       = mau_pkg::OP_ADD;
                u_r        = c0_reg;
                u_x        = pr_reg;
                c1_next    = u_res;
                c0_next    = c1_reg;
                r0_next    = r1_reg;
                r1_next    = rem_reg;
                state_next = S_EU;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg  <= ret_next;
        cnt_reg  <= cnt_next;
        mode_reg <= mode_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        e_reg    <= e_next;
        pr_reg   <= pr_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        c0_reg   <= c0_next;
        c1_reg   <= c1_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        rsp_reg  <= rsp_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = rsp_reg;

endmodule
